// ----- src/fsla_pkg.sv -----
// Package for the free-list slot allocator: types, codes and constants.
// Used by the configuration register block and the top level.
package fsla_pkg;

    localparam int unsigned CAPACITY = 1024;
    localparam int unsigned SLOT_W   = $clog2(CAPACITY);
    localparam int unsigned COUNT_W  = SLOT_W + 1;
    localparam int unsigned APB_AW   = 6;
    localparam int unsigned APB_DW   = 64;
    localparam int unsigned ALIGN_W  = 8;

    localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(CAPACITY);
    localparam logic [SLOT_W-1:0]  LAST_SLOT      = SLOT_W'(CAPACITY - 1);

    typedef enum logic [2:0] {
        REG_POOL_COUNT        = 3'd0,
        REG_SLOT_BYTES        = 3'd1,
        REG_BUFFER_BASE       = 3'd2,
        REG_DESCRIPTOR_BASE   = 3'd3,
        REG_DESCRIPTOR_STRIDE = 3'd4
    } reg_index_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_EMPTY        = 2'd1,
        STAT_NOT_IN_USE   = 2'd2,
        STAT_OUT_OF_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_SWEEP,
        FSM_IDLE,
        FSM_EXEC,
        FSM_ADDR
    } fsm_state_t;

    typedef struct packed {
        logic [10:0] pool_count;
        logic [15:0] slot_bytes;
        logic [63:0] buffer_base;
        logic [63:0] descriptor_base;
        logic [12:0] descriptor_stride;
    } cfg_t;

endpackage

// ----- src/fsla_if.sv -----
// Handshake interfaces for the allocator's request and response channels.
// Depends on nothing; payload widths follow the request and result fields.
interface fsla_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [9:0] free_slot;

    modport source (output valid, output opcode, output free_slot, input ready);
    modport sink   (input valid, input opcode, input free_slot, output ready);
endinterface

interface fsla_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  slot_id;
    logic [63:0] slot_address;
    logic [63:0] slot_descriptor;
    logic [10:0] free_left;

    modport source (output valid, output status, output slot_id, output slot_address,
                    output slot_descriptor, output free_left, input ready);
    modport sink   (input valid, input status, input slot_id, input slot_address,
                    input slot_descriptor, input free_left, output ready);
endinterface

// ----- src/fsla_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module fsla_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fsla_cfg.sv -----
// Configuration registers of the allocator behind an APB-style port.
// Depends on fsla_pkg; signals a refill whenever the pool count is written.
module fsla_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fsla_pkg::APB_AW-1:0] paddr,
    input  logic [fsla_pkg::APB_DW-1:0] pwdata,
    output logic [fsla_pkg::APB_DW-1:0] prdata,
    output fsla_pkg::cfg_t             cfg,
    output logic                       refill
);
    import fsla_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       write_en;
    reg_index_t index;

    assign write_en = psel && penable && pwrite;
    assign index    = reg_index_t'(paddr[5:3]);

    always_comb
    begin
        cfg_next = cfg_reg;
        refill   = 1'b0;
        prdata   = '0;
        unique case (index)
            REG_POOL_COUNT:
            begin
                prdata = {53'd0, cfg_reg.pool_count};
                if (write_en)
                begin
                    cfg_next.pool_count = pwdata[10:0];
                    refill              = 1'b1;
                end
            end
            REG_SLOT_BYTES:
            begin
                prdata = {48'd0, cfg_reg.slot_bytes};
                if (write_en)
                begin
                    cfg_next.slot_bytes = pwdata[15:0];
                end
            end
            REG_BUFFER_BASE:
            begin
                prdata = cfg_reg.buffer_base;
                if (write_en)
                begin
                    cfg_next.buffer_base = pwdata;
                end
            end
            REG_DESCRIPTOR_BASE:
            begin
                prdata = cfg_reg.descriptor_base;
                if (write_en)
                begin
                    cfg_next.descriptor_base = pwdata;
                end
            end
            REG_DESCRIPTOR_STRIDE:
            begin
                prdata = {51'd0, cfg_reg.descriptor_stride};
                if (write_en)
                begin
                    cfg_next.descriptor_stride = pwdata[12:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pool_count        <= 11'd1024;
            cfg_reg.slot_bytes        <= 16'd256;
            cfg_reg.buffer_base       <= 64'd0;
            cfg_reg.descriptor_base   <= 64'd0;
            cfg_reg.descriptor_stride <= 13'd32;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/free_list_slot_allocator_unit.sv -----
// Top level of the free-list slot allocator: free-id ring and in-use bitmap in RAM.
// Depends on fsla_pkg, fsla_req_if, fsla_rsp_if, fsla_ram and fsla_cfg.
//
//   Channel   Direction  Handshake              Payload
//   req       in         valid / ready          opcode, free_slot
//   rsp       out        valid / ready          status, slot_id, slot_address,
//                                               slot_descriptor, free_left
//   apb       in         psel, penable, pready  paddr, pwdata, prdata
//
// Each transaction goes through three steps: accept and RAM read, read-modify-write
// of the ring and bitmap with the address multiplies, then the base adds into the
// output register. After reset and after every pool_count write, a clearing pass
// over every RAM entry reloads the ring with ids in order and clears the bitmap;
// req is not ready meanwhile. A stalled response holds the third step until rsp is free.
module free_list_slot_allocator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fsla_pkg::APB_AW-1:0] paddr,
    input  logic [fsla_pkg::APB_DW-1:0] pwdata,
    output logic [fsla_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    fsla_req_if.sink                    req,
    fsla_rsp_if.source                  rsp
);
    import fsla_pkg::*;

    cfg_t               cfg;
    logic               refill;
    logic [COUNT_W-1:0] live_count;

    fsm_state_t         state_reg, state_next;
    logic [SLOT_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [SLOT_W-1:0]  tail_reg, tail_next;
    logic [COUNT_W-1:0] free_total_reg, free_total_next;

    opcode_t            op_reg, op_next;
    logic [SLOT_W-1:0]  req_slot_reg, req_slot_next;
    status_t            status_reg, status_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [17:0]        addr_prod_reg, addr_prod_next;
    logic [22:0]        desc_prod_reg, desc_prod_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [63:0]        out_addr_reg, out_addr_next;
    logic [63:0]        out_desc_reg, out_desc_next;
    logic [COUNT_W-1:0] out_left_reg, out_left_next;

    logic               ring_we;
    logic [SLOT_W-1:0]  ring_waddr;
    logic [SLOT_W-1:0]  ring_wdata;
    logic [SLOT_W-1:0]  ring_rdata;
    logic               busy_we;
    logic [SLOT_W-1:0]  busy_waddr;
    logic               busy_wdata;
    logic [SLOT_W-1:0]  busy_raddr;
    logic               busy_rdata;

    logic               in_fire;
    logic               out_load;
    logic               alloc_ok;

    fsla_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .refill  (refill)
    );

    assign pready = 1'b1;

    fsla_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    fsla_ram #(
        .WIDTH (1),
        .DEPTH (CAPACITY)
    ) u_busy_ram (
        .clk   (clk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .raddr (busy_raddr),
        .rdata (busy_rdata)
    );

    assign live_count = (cfg.pool_count > CAPACITY_COUNT) ? CAPACITY_COUNT : cfg.pool_count;
    assign req.ready  = (state_reg == FSM_IDLE);
    assign in_fire    = req.valid && req.ready;
    assign busy_raddr = req.free_slot;
    assign out_load   = (state_reg == FSM_ADDR) && (!out_valid_reg || rsp.ready);
    assign alloc_ok   = (op_reg == OP_ALLOC) && (status_reg == STAT_OK);

    always_comb
    begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_total_next = free_total_reg;
        op_next         = op_reg;
        req_slot_next   = req_slot_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        addr_prod_next  = addr_prod_reg;
        desc_prod_next  = desc_prod_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_addr_next   = out_addr_reg;
        out_desc_next   = out_desc_reg;
        out_left_next   = out_left_reg;
        ring_we         = 1'b0;
        ring_waddr      = tail_reg;
        ring_wdata      = req_slot_reg;
        busy_we         = 1'b0;
        busy_waddr      = req_slot_reg;
        busy_wdata      = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_SWEEP:
            begin
                ring_we        = 1'b1;
                ring_waddr     = sweep_cnt_reg;
                ring_wdata     = sweep_cnt_reg;
                busy_we        = 1'b1;
                busy_waddr     = sweep_cnt_reg;
                busy_wdata     = 1'b0;
                sweep_cnt_next = sweep_cnt_reg + SLOT_W'(1);
                if (sweep_cnt_reg == LAST_SLOT)
                begin
                    tail_next       = live_count[SLOT_W-1:0];
                    free_total_next = live_count;
                    state_next      = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                if (in_fire)
                begin
                    op_next       = opcode_t'(req.opcode);
                    req_slot_next = req.free_slot;
                    if (opcode_t'(req.opcode) == OP_ALLOC)
                    begin
                        status_next = (free_total_reg == '0) ? STAT_EMPTY : STAT_OK;
                    end
                    else
                    begin
                        status_next = ({1'b0, req.free_slot} >= live_count) ?
                                      STAT_OUT_OF_RANGE : STAT_OK;
                    end
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                slot_next = '0;
                if (status_reg == STAT_OK)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        slot_next       = ring_rdata;
                        busy_we         = 1'b1;
                        busy_waddr      = ring_rdata;
                        busy_wdata      = 1'b1;
                        head_next       = head_reg + SLOT_W'(1);
                        free_total_next = free_total_reg - COUNT_W'(1);
                    end
                    else if (!busy_rdata)
                    begin
                        status_next = STAT_NOT_IN_USE;
                    end
                    else
                    begin
                        busy_we         = 1'b1;
                        busy_waddr      = req_slot_reg;
                        busy_wdata      = 1'b0;
                        ring_we         = 1'b1;
                        ring_waddr      = tail_reg;
                        ring_wdata      = req_slot_reg;
                        tail_next       = tail_reg + SLOT_W'(1);
                        free_total_next = free_total_reg + COUNT_W'(1);
                    end
                end
                addr_prod_next = 18'(slot_next) * 18'(cfg.slot_bytes[15:ALIGN_W]);
                desc_prod_next = 23'(slot_next) * 23'(cfg.descriptor_stride);
                state_next     = FSM_ADDR;
            end
            FSM_ADDR:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_slot_next   = slot_reg;
                    out_left_next   = free_total_reg;
                    if (alloc_ok)
                    begin
                        out_addr_next = cfg.buffer_base + {38'd0, addr_prod_reg, 8'd0};
                        out_desc_next = cfg.descriptor_base + {41'd0, desc_prod_reg};
                    end
                    else
                    begin
                        out_addr_next = '0;
                        out_desc_next = '0;
                    end
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_SWEEP;
            end
        endcase

        if (refill)
        begin
            state_next     = FSM_SWEEP;
            sweep_cnt_next = '0;
            head_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_SWEEP;
            sweep_cnt_reg  <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            free_total_reg <= CAPACITY_COUNT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_total_reg <= free_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_slot_reg   <= req_slot_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        addr_prod_reg  <= addr_prod_next;
        desc_prod_reg  <= desc_prod_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_addr_reg   <= out_addr_next;
        out_desc_reg   <= out_desc_next;
        out_left_reg   <= out_left_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.slot_id         = out_slot_reg;
    assign rsp.slot_address    = out_addr_reg;
    assign rsp.slot_descriptor = out_desc_reg;
    assign rsp.free_left       = out_left_reg;

endmodule
